### sv/cfaq_pkg.sv
// ----------------------------------------------------------------------------
// cfaq_pkg: shared constants, codes and helpers of the frame assembler queue
// Sizes of the slot ring, status and mode codes, the first-byte length
// decoder and the address map of the frame memory.
// ----------------------------------------------------------------------------
package cfaq_pkg;

	localparam int FRAME_SLOTS     = 8;
	localparam int MAX_FRAME_BYTES = 16;

	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int POS_W  = $clog2(MAX_FRAME_BYTES);
	localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int DEPTH  = FRAME_SLOTS * MAX_FRAME_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [1:0] STAT_ACCEPT = 2'd0;
	localparam logic [1:0] STAT_DROP   = 2'd1;
	localparam logic [1:0] STAT_BYTE   = 2'd2;
	localparam logic [1:0] STAT_EMPTY  = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_POP
	} seq_state_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic              hf_push;
		logic              hf_pop;
		logic [ADDR_W-1:0] wr_addr;
		logic [SLOT_W-1:0] rd_slot;
		logic [CNT_W-1:0]  rd_fill;
	} ring_info_t;

	// Frame length in bytes, decoded from the first byte of a frame.
	function automatic logic [CNT_W-1:0] frame_len(input logic [7:0] b);
		logic [3:0] lo;
		logic [1:0] a;
		logic [1:0] c;
		logic [3:0] hi;
		logic [CNT_W-1:0] n;
		lo = b[3:0];
		a  = b[5:4];
		c  = b[7:6];
		hi = b[7:4];
		unique case (lo)
			4'd0, 4'd1, 4'd2, 4'd7, 4'd8: n = CNT_W'(1);
			4'd3: begin
				if (a == 2'b11) begin
					n = (c != 2'b00) ? CNT_W'(4) : CNT_W'(2);
				end else if (c == 2'b11) begin
					n = CNT_W'(3);
				end else begin
					n = CNT_W'(3) + ((a != 2'b00) ? CNT_W'(2) : CNT_W'(0))
						+ ((c != 2'b00) ? CNT_W'(2) : CNT_W'(0));
				end
			end
			4'd4: begin
				n = CNT_W'(3) + ((a != 2'b00) ? CNT_W'(4) : CNT_W'(0))
					+ ((c != 2'b00) ? CNT_W'(4) : CNT_W'(0));
			end
			4'd5: n = CNT_W'(9);
			4'd6: n = (hi >= 4'd1 && hi <= 4'd4) ? CNT_W'(2) : CNT_W'(1);
			default: n = CNT_W'(MAX_FRAME_BYTES);
		endcase
		return n;
	endfunction

	// Control and query frames are flagged as priority.
	function automatic logic is_priority(input logic [7:0] b);
		return (b[3:0] == 4'd1) || (b[3:0] == 4'd2);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
		input logic [POS_W-1:0] p);
		return ADDR_W'(s) * ADDR_W'(MAX_FRAME_BYTES) + ADDR_W'(p);
	endfunction

endpackage

### sv/cfaq_ram.sv
// ----------------------------------------------------------------------------
// cfaq_ram: generic simple dual-port RAM
// One write port and one read port with a registered read; the read data
// holds while no read is enabled.
// ----------------------------------------------------------------------------
module cfaq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/cfaq_ring.sv
// ----------------------------------------------------------------------------
// cfaq_ring: slot ring bookkeeping
// Write and read slot pointers, the empty flag, the byte position of the frame
// being assembled and a fill count per slot that masks stale memory bytes.
// ----------------------------------------------------------------------------
module cfaq_ring import cfaq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_en,
	input  logic       pop_en,
	input  logic [7:0] data_byte,
	output ring_info_t info
);

	logic [SLOT_W-1:0] ws_q;
	logic [SLOT_W-1:0] rs_q;
	logic              empty_q;
	logic [POS_W-1:0]  bp_q;
	logic [7:0]        first_q;
	logic [CNT_W-1:0]  fill_q [FRAME_SLOTS];

	logic [CNT_W-1:0]  len;
	logic [CNT_W-1:0]  bp_next;
	logic              done;
	logic [SLOT_W-1:0] rs_inc;

	always_comb begin
		len     = frame_len((bp_q == '0) ? data_byte : first_q);
		bp_next = CNT_W'(bp_q) + CNT_W'(1);
		done    = (bp_q == POS_W'(MAX_FRAME_BYTES - 1)) || (bp_next >= len);
		rs_inc  = slot_inc(rs_q);

		info.full    = !empty_q && (ws_q == rs_q);
		info.empty   = empty_q;
		info.hf_push = !(empty_q && !done);
		info.hf_pop  = (rs_inc != ws_q);
		info.wr_addr = slot_addr(ws_q, bp_q);
		info.rd_slot = rs_q;
		info.rd_fill = fill_q[rs_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= '0;
			rs_q    <= '0;
			empty_q <= 1'b1;
			bp_q    <= '0;
			for (int i = 0; i < FRAME_SLOTS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (push_en) begin
			fill_q[ws_q] <= bp_next;
			if (done) begin
				bp_q <= '0;
				ws_q <= slot_inc(ws_q);
				if (empty_q) begin
					rs_q    <= ws_q;
					empty_q <= 1'b0;
				end
			end else begin
				bp_q <= bp_q + 1'b1;
			end
		end else if (pop_en) begin
			fill_q[rs_q] <= '0;
			rs_q         <= rs_inc;
			empty_q      <= (rs_inc == ws_q);
		end
	end

	// The first byte of the frame under assembly sets its length.
	always_ff @(posedge clk) begin
		if (push_en && bp_q == '0) begin
			first_q <= data_byte;
		end
	end

endmodule

### sv/command_frame_assembler_queue_top.sv
// ----------------------------------------------------------------------------
// command_frame_assembler_queue_top: command frame assembler and frame queue
// Pushed bytes build command frames in a ring of slots held in one frame memory;
// a pop streams the oldest complete frame out one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   channel | signals                                          | dir | per request
//   --------+--------------------------------------------------+-----+--------------
//   in      | in_valid, in_ready, mode, data_byte              | in  | push or pop
//   out     | out_valid, out_ready, status, out_byte,          | out | 1 on push or
//           | priority_res, last, has_frame                    |     | empty pop,
//           |                                                  |     | else 16 bytes
//
// A push writes the byte into the frame memory and registers its result in the
// output stage at the same edge.
// A pop of a waiting frame reads the frame memory one position per cycle while
// the output is not stalled; it occupies the block from the accepting cycle
// through one read per position until the last byte has left the read stage,
// after which the next request is taken.
// Output stalls hold the sequencer: a position is read only when the read
// stage will be free, so a stalled byte is never lost or overwritten.
// Reset is asynchronous and clears the ring pointers, the fill counts and the
// control state; no memory clearing pass is needed, as positions beyond a
// slot's fill count read as zero.
//
module command_frame_assembler_queue_top import cfaq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [7:0] out_byte,
	output logic       priority_res,
	output logic       last,
	output logic       has_frame
);

	ring_info_t info;

	seq_state_t state_q;
	seq_state_t state_d;

	logic in_ready_c;
	logic in_acc;
	logic push_acc;
	logic pop_acc;
	logic push_go;
	logic pop_go;
	logic direct_res;

	// Pop sequencer registers.
	logic [SLOT_W-1:0] pop_slot_q;
	logic [CNT_W-1:0]  pop_fill_q;
	logic              pop_hf_q;
	logic [POS_W-1:0]  k_q;
	logic              pr_q;

	// Frame memory ports.
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	// Read stage: the memory's output register plus its side-band bits.
	logic s1_valid_s1;
	logic keep_s1;
	logic last_s1;
	logic first_s1;

	logic out_valid_q;
	logic out_free;
	logic load_s1;
	logic pr_now;

	// Request decoding. A pop of a waiting frame starts the sequencer and
	// gives no result of its own; every other request answers at once.
	always_comb begin
		in_acc     = in_valid && in_ready_c;
		push_acc   = in_acc && (mode == MODE_PUSH);
		pop_acc    = in_acc && (mode == MODE_POP);
		push_go    = push_acc && !info.full;
		pop_go     = pop_acc && !info.empty;
		direct_res = push_acc || (pop_acc && info.empty);
		out_free   = !out_valid_q || out_ready;
		load_s1    = s1_valid_s1 && out_free;
		pr_now     = first_s1 ? is_priority(ram_rdata) : pr_q;
		ram_raddr  = slot_addr(pop_slot_q, k_q);
	end

	assign in_ready = in_ready_c;

	cfaq_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (push_go),
		.pop_en    (pop_go),
		.data_byte (data_byte),
		.info      (info)
	);

	cfaq_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_frame_mem (
		.clk   (clk),
		.we    (push_go),
		.waddr (info.wr_addr),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (pop_go) begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (ram_re && k_q == POS_W'(MAX_FRAME_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs. New requests wait until the read stage has drained.
	always_comb begin
		in_ready_c = 1'b0;
		ram_re     = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready_c = !s1_valid_s1 && out_free;
			S_POP:  ram_re     = !s1_valid_s1 || out_free;
			default: begin
				in_ready_c = 1'b0;
				ram_re     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop_go) begin
				k_q <= '0;
			end else if (ram_re) begin
				k_q <= k_q + 1'b1;
			end
			if (ram_re) begin
				s1_valid_s1 <= 1'b1;
			end else if (out_free) begin
				s1_valid_s1 <= 1'b0;
			end
			if (load_s1 || direct_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Frame context captured when a pop starts; the ring has already moved on.
	always_ff @(posedge clk) begin
		if (pop_go) begin
			pop_slot_q <= info.rd_slot;
			pop_fill_q <= info.rd_fill;
			pop_hf_q   <= info.hf_pop;
		end
		if (ram_re) begin
			keep_s1  <= (CNT_W'(k_q) < pop_fill_q);
			last_s1  <= (k_q == POS_W'(MAX_FRAME_BYTES - 1));
			first_s1 <= (k_q == '0);
		end
		if (load_s1 && first_s1) begin
			pr_q <= pr_now;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			status       <= STAT_BYTE;
			out_byte     <= keep_s1 ? ram_rdata : 8'd0;
			priority_res <= pr_now;
			last         <= last_s1;
			has_frame    <= pop_hf_q;
		end else if (direct_res) begin
			out_byte     <= 8'd0;
			priority_res <= 1'b0;
			last         <= 1'b1;
			if (pop_acc) begin
				status    <= STAT_EMPTY;
				has_frame <= 1'b0;
			end else if (info.full) begin
				status    <= STAT_DROP;
				has_frame <= 1'b1;
			end else begin
				status    <= STAT_ACCEPT;
				has_frame <= info.hf_push;
			end
		end
	end

	assign out_valid = out_valid_q;

	// The closing byte of a frame can only leave once the sequencer is idle.
	a_last_byte_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && status == STAT_BYTE && last) |-> (state_q == S_IDLE))
		else $error("frame closed while the pop sequencer was still running");

	// A started pop begins reading at the first position of the slot.
	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		pop_go |=> (state_q == S_POP && k_q == '0))
		else $error("pop did not start at position zero");

	// No push may write the frame memory during a pop or while a popped byte sits in the read stage.
	a_no_write_in_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 || state_q == S_POP) |-> !push_go)
		else $error("frame memory written during a pop");

	// Every result other than a frame byte is the only result of its request.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_BYTE) |-> last)
		else $error("single result without last");

endmodule
